@@ sv/hrsl_pkg.sv @@
// Package for the history record start locator.
// Holds widths, character codes and shared types; no dependencies.
package hrsl_pkg;
    localparam int OFFSET_BITS = 32;
    localparam int STAMP_BITS  = 63;
    localparam int CNT_BITS    = 32;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 64;

    localparam logic [ADDR_BITS-1:0] REG_CUTOFF = '0;

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
    localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;

    typedef enum logic [2:0] {
        CL_START, CL_REPEAT, CL_TAIL, CL_PLAIN, CL_SKIP, CL_DOTS, CL_DASHES, CL_SPACE
    } t_class;

    typedef enum logic [2:0] {
        PH_LEAD, PH_WORD, PH_GAP, PH_ZERO, PH_HEXX, PH_DIGITS, PH_STOP
    } t_phase;

    typedef enum logic [1:0] {RX_DEC, RX_OCT, RX_HEX} t_radix;

    // Pattern "- cmd: " and "   when:" (index 0 first).
    function automatic logic [7:0] rep_char(input logic [3:0] i);
        case (i)
            4'd0: rep_char = 8'h2D;
            4'd1: rep_char = 8'h20;
            4'd2: rep_char = 8'h63;
            4'd3: rep_char = 8'h6D;
            4'd4: rep_char = 8'h64;
            4'd5: rep_char = 8'h3A;
            4'd6: rep_char = 8'h20;
            default: rep_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] tail_char(input logic [3:0] i);
        case (i)
            4'd0, 4'd1, 4'd2: tail_char = 8'h20;
            4'd3: tail_char = 8'h77;
            4'd4: tail_char = 8'h68;
            4'd5: tail_char = 8'h65;
            4'd6: tail_char = 8'h6E;
            4'd7: tail_char = 8'h3A;
            default: tail_char = 8'h00;
        endcase
    endfunction

    // Hex digit value, 16 when not a digit.
    function automatic logic [4:0] digit_of(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) digit_of = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) digit_of = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) digit_of = 5'(b - 8'h37);
        else digit_of = 5'd16;
    endfunction

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    // Line-end summary handed from the scanner to the record decider.
    typedef struct packed {
        logic                   valid;
        logic                   end_of_data;
        logic                   at_line_head;
        logic                   byte_space;
        logic                   newline;
        logic                   is_record;
        logic                   is_stamp;
        logic [OFFSET_BITS-1:0] rec_offset;
        logic [STAMP_BITS-1:0]  stamp;
    } t_line_evt;
endpackage

@@ sv/hrsl_stream_if.sv @@
// Valid/ready channel interface for the locator.
// Depends on nothing but a payload width.
interface hrsl_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ sv/hrsl_scan.sv @@
// Per-byte line scanner: classifies lines and parses the when: stamp.
// Depends on hrsl_pkg.
module hrsl_scan
    import hrsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output t_line_evt o_evt
);
    logic [OFFSET_BITS-1:0] r_pos, n_pos, r_lstart;
    logic [CNT_BITS-1:0]    r_len, n_len, r_reps, n_reps;
    logic [3:0]             r_idx, n_idx;
    t_class                 r_cls, n_cls;
    t_phase                 r_ph, n_ph;
    logic [STAMP_BITS-1:0]  r_val, n_val;
    t_radix                 r_rx, n_rx;
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] lstart;
    logic [CNT_BITS-1:0]    k;
    logic [4:0]             d;
    logic [4:0]             base;
    logic [STAMP_BITS+4:0]  prod;
    logic                   rec;

    assign b = i_item.data_byte;
    assign lstart = (r_len == '0) ? r_pos : r_lstart;

    always_comb begin
        d = digit_of(b);
        base = (r_rx == RX_HEX) ? 5'd16 : ((r_rx == RX_OCT) ? 5'd8 : 5'd10);
        prod = {5'd0, r_val} * base + {{(STAMP_BITS){1'b0}}, d};
    end

    always_comb begin
        n_idx = r_idx;
        n_cls = r_cls;
        n_ph = r_ph;
        n_val = r_val;
        n_rx = r_rx;
        n_reps = r_reps;
        n_len = r_len;
        rec = 1'b0;
        k = '0;
        if (b == 8'h0A) begin
            rec = r_len >= CNT_BITS'(3) &&
                (r_cls == CL_REPEAT || r_cls == CL_TAIL || r_cls == CL_PLAIN);
            k = (r_reps >= CNT_BITS'(1)) ? r_reps - 1'b1 : '0;
            if (r_cls == CL_REPEAT && r_idx == 4'd0 && k != '0) k = k - 1'b1;
            n_len = '0; n_reps = '0; n_idx = '0; n_cls = CL_START;
            n_ph = PH_LEAD; n_val = '0; n_rx = RX_DEC;
        end else begin
            if (r_len != CNT_MAX) n_len = r_len + 1'b1;
            case (r_cls)
                CL_START: begin
                    if (b == 8'h20) n_cls = CL_SPACE;
                    else if (b == 8'h25) n_cls = CL_SKIP;
                    else if (b == 8'h2D) begin n_cls = CL_REPEAT; n_idx = 4'd1; end
                    else if (b == 8'h2E) n_cls = CL_DOTS;
                    else n_cls = CL_PLAIN;
                end
                CL_REPEAT: begin
                    if (r_idx < 4'd7 && b == rep_char(r_idx)) begin
                        n_idx = r_idx + 4'd1;
                        if (r_idx == 4'd6) begin
                            n_idx = '0;
                            if (r_reps != CNT_MAX) n_reps = r_reps + 1'b1;
                        end
                    end else if (r_idx == 4'd0) begin
                        if (b == tail_char(4'd0)) begin n_cls = CL_TAIL; n_idx = 4'd1; end
                        else n_cls = CL_PLAIN;
                    end else if (r_reps == '0 && r_idx == 4'd1 && b == 8'h2D) begin
                        n_cls = CL_DASHES;
                    end else n_cls = CL_PLAIN;
                end
                CL_TAIL: begin
                    if (r_idx < 4'd8 && b == tail_char(r_idx)) begin
                        n_idx = r_idx + 4'd1;
                        if (r_idx == 4'd7) n_cls = CL_SKIP;
                    end else n_cls = CL_PLAIN;
                end
                CL_DOTS: begin
                    if (b == 8'h2E) begin
                        if (r_len != CNT_BITS'(1)) n_cls = CL_SKIP;
                    end else n_cls = CL_PLAIN;
                end
                CL_DASHES: n_cls = (b == 8'h2D) ? CL_SKIP : CL_PLAIN;
                default: ;
            endcase
            // Stamp parse runs on space-led lines only.
            if ((r_cls == CL_START && b == 8'h20) || r_cls == CL_SPACE) begin
                case (r_ph)
                    PH_LEAD: if (b != 8'h20) begin
                        if (b == 8'h77) begin n_ph = PH_WORD; n_idx = 4'd1; end
                        else n_ph = PH_STOP;
                    end
                    PH_WORD: begin
                        if (r_idx < 4'd5 && b == tail_char(r_idx + 4'd3)) begin
                            n_idx = r_idx + 4'd1;
                            if (r_idx == 4'd4) n_ph = PH_GAP;
                        end else n_ph = PH_STOP;
                    end
                    PH_GAP: if (b != 8'h20) begin
                        if (b == 8'h30) begin n_ph = PH_ZERO; n_rx = RX_OCT; end
                        else if (b >= 8'h31 && b <= 8'h39) begin
                            n_val = STAMP_BITS'(d); n_rx = RX_DEC; n_ph = PH_DIGITS;
                        end else n_ph = PH_STOP;
                    end
                    PH_ZERO: begin
                        if (b == 8'h78 || b == 8'h58) n_ph = PH_HEXX;
                        else if (b >= 8'h30 && b <= 8'h37) begin
                            n_val = STAMP_BITS'(d); n_ph = PH_DIGITS;
                        end else n_ph = PH_STOP;
                    end
                    PH_HEXX: begin
                        if (d < 5'd16) begin
                            n_val = STAMP_BITS'(d); n_rx = RX_HEX; n_ph = PH_DIGITS;
                        end else n_ph = PH_STOP;
                    end
                    PH_DIGITS: begin
                        if (d < base) begin
                            if (prod[STAMP_BITS+4:STAMP_BITS] != '0) n_val = STAMP_MAX;
                            else n_val = prod[STAMP_BITS-1:0];
                        end else n_ph = PH_STOP;
                    end
                    default: ;
                endcase
            end
        end
        n_pos = r_pos + 1'b1;
        if (i_item.end_of_data) begin
            n_pos = '0; n_len = '0; n_reps = '0; n_idx = '0; n_cls = CL_START;
            n_ph = PH_LEAD; n_val = '0; n_rx = RX_DEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_lstart <= '0; r_len <= '0; r_reps <= '0; r_idx <= '0;
            r_cls <= CL_START; r_ph <= PH_LEAD; r_val <= '0; r_rx <= RX_DEC;
            o_evt <= '0;
        end else begin
            o_evt.valid <= i_valid;
            if (i_valid) begin
                r_pos <= n_pos; r_lstart <= lstart; r_len <= n_len; r_reps <= n_reps;
                r_idx <= n_idx; r_cls <= n_cls; r_ph <= n_ph; r_val <= n_val; r_rx <= n_rx;
                o_evt.end_of_data  <= i_item.end_of_data;
                o_evt.at_line_head <= (r_len == '0);
                o_evt.byte_space   <= (b == 8'h20);
                o_evt.newline      <= (b == 8'h0A);
                o_evt.is_record    <= rec;
                o_evt.is_stamp     <= (r_cls == CL_SPACE);
                o_evt.rec_offset   <= lstart + OFFSET_BITS'(k * CNT_BITS'(7));
                o_evt.stamp        <= r_val;
            end
        end
    end
endmodule

@@ sv/hrsl_decide.sv @@
// Record decider: holds a pending record and emits offsets.
// Depends on hrsl_pkg.
module hrsl_decide
    import hrsl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_line_evt              i_evt,
    input  logic [STAMP_BITS-1:0]  i_cutoff,
    output logic                   o_valid,
    output logic [OFFSET_BITS-1:0] o_offset
);
    logic                   r_pend, n_pend;
    logic [OFFSET_BITS-1:0] r_poff, n_poff;
    logic                   emit;
    logic [OFFSET_BITS-1:0] eoff;

    always_comb begin
        n_pend = r_pend;
        n_poff = r_poff;
        emit = 1'b0;
        eoff = r_poff;
        if (i_evt.at_line_head && r_pend && !i_evt.byte_space) begin
            emit = 1'b1;
            n_pend = 1'b0;
        end
        if (i_evt.newline) begin
            if (i_evt.is_stamp) begin
                if (n_pend && i_evt.stamp != '0) begin
                    if (!(i_cutoff != '0 && i_evt.stamp > i_cutoff)) emit = 1'b1;
                    n_pend = 1'b0;
                end
            end else if (i_evt.is_record) begin
                if (i_cutoff == '0) begin
                    emit = 1'b1; eoff = i_evt.rec_offset;
                end else begin
                    n_pend = 1'b1; n_poff = i_evt.rec_offset;
                end
            end
        end
        if (i_evt.end_of_data) begin
            if (n_pend && !emit) begin emit = 1'b1; eoff = n_poff; end
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0; r_poff <= '0; o_valid <= 1'b0;
        end else begin
            o_valid <= i_evt.valid && emit;
            if (i_evt.valid) begin
                r_pend <= n_pend; r_poff <= n_poff; o_offset <= eoff;
            end
        end
    end
endmodule

@@ sv/history_record_start_locator.sv @@
// Top level of the history record start locator.
// Depends on hrsl_pkg, hrsl_stream_if, hrsl_scan and hrsl_decide.
//
// Usage: log bytes enter on in_ch (data = {data_byte, end_of_data}), one
// transfer per cycle while ready is high. Record-start offsets leave on
// out_ch (data = item_offset). The APB port writes cutoff_time at address
// 0 (64-bit data, byte address 8*i); zero disables stamp filtering.
// Pipeline: a scanner register stage then a decider stage, whose result
// is written into the result FIFO; a new byte is taken every cycle while
// input ready is high.
// Stall: a 4-entry FIFO holds results; input ready drops only when the
// FIFO entries plus the two pipeline slots in flight reach four, so
// nothing is lost and a steadily drained output keeps full input rate.
// Reset (synchronous, i_rst_n low) clears scan position, pending record,
// FIFO and cutoff. end_of_data flushes a pending record and restarts the
// scan at offset 0.
module history_record_start_locator
    import hrsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hrsl_stream_if.sink           in_ch,
    hrsl_stream_if.source         out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS:0]    paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);
    logic [STAMP_BITS-1:0]  r_cutoff;
    logic                   acc, s1_valid, d_valid;
    t_in_item               item;
    t_line_evt              evt;
    logic [OFFSET_BITS-1:0] d_off;
    logic [OFFSET_BITS-1:0] r_fifo [4];
    logic [2:0]             r_cnt;
    logic [1:0]             r_wp, r_rp;
    logic [2:0]             fill_sum;
    logic                   pop;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_BITS:ADDR_BITS] == 1'b0 && paddr[ADDR_BITS-1:0] == REG_CUTOFF)
                  ? {1'b0, r_cutoff} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cutoff <= '0;
        else if (psel && penable && pwrite && paddr == {1'b0, REG_CUTOFF})
            r_cutoff <= pwdata[STAMP_BITS-1:0];
    end

    // Accept only when FIFO room covers every result still in flight.
    assign fill_sum = r_cnt + {2'b00, s1_valid} + {2'b00, d_valid};
    assign in_ch.ready = (fill_sum < 3'd4);
    assign acc  = in_ch.valid && in_ch.ready;
    assign item = in_ch.data;
    assign s1_valid = evt.valid;

    hrsl_scan u_scan (
        .i_clk, .i_rst_n, .i_valid(acc), .i_item(item), .o_evt(evt)
    );

    hrsl_decide u_decide (
        .i_clk, .i_rst_n, .i_evt(evt), .i_cutoff(r_cutoff),
        .o_valid(d_valid), .o_offset(d_off)
    );

    assign out_ch.valid = (r_cnt != 3'd0);
    assign out_ch.data  = r_fifo[r_rp];
    assign pop = out_ch.valid && out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= '0; r_rp <= '0;
        end else begin
            if (d_valid) begin
                r_fifo[r_wp] <= d_off;
                r_wp <= r_wp + 2'd1;
            end
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b00, d_valid} - {2'b00, pop};
        end
    end
endmodule
